/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expr");

// cons must follow ante (cons may carry its own cycle delay)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed: ante -> cons");

`endif

/* hw/rtl/ltrc_pkg.sv */
package ltrc_pkg;

   localparam int TILE_SIZE_DEF    = 16;
   localparam int MAX_VIEWPORT_DEF = 4096;

   localparam int DIM_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_SCALE_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_SCALE_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_PLANE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_PLANE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_HEIGHT = 3'd5;

   localparam logic [23:0]      RST_SCALE  = 24'd65536;
   localparam logic [30:0]      RST_NEAR   = 31'd6554;
   localparam logic [30:0]      RST_FAR    = 31'd65536000;
   localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd1920;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd1080;

   // 0.05 in Q16.16
   localparam logic [30:0] RANGE_MIN_Q = 31'd3277;

   // pipelined dividers: quotient bits resolved per stage
   localparam int DIV_STEP     = 4;
   localparam int RATIO_NUM_W  = 55;
   localparam int RATIO_DEN_W  = 31;
   localparam int RATIO_Q_W    = 32;
   localparam int SCREEN_NUM_W = 62;
   localparam int SCREEN_DEN_W = 33;
   localparam int SCREEN_Q_W   = 48;
   localparam int RATIO_LAT    = RATIO_Q_W / DIV_STEP;
   localparam int SCREEN_LAT   = SCREEN_Q_W / DIV_STEP;
   // accept edge to the edge that takes the result
   localparam int LATENCY      = SCREEN_LAT + 6;

   localparam int RX_W  = 44;
   localparam int POS_W = 50;
   localparam logic [SCREEN_Q_W:0] SCREEN_LIM = 49'h0_8000_0000_0000;

   typedef enum logic [1:0] {
      VERDICT_CULLED = 2'd0,
      VERDICT_ALL    = 2'd1,
      VERDICT_RECT   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [23:0]      scale_x;
      logic [23:0]      scale_y;
      logic [30:0]      near_plane;
      logic [30:0]      far_plane;
      logic [DIM_W-1:0] dim_x;
      logic [DIM_W-1:0] dim_y;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      verdict_type verdict;
      logic        geom;
      logic        neg_x;
      logic        neg_y;
   } side_type;

endpackage

/* hw/rtl/ltrc_front.sv */
module ltrc_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic                                   kind,
   input  logic [31:0]                            view_depth,
   input  logic [31:0]                            clip_x,
   input  logic [31:0]                            clip_y,
   input  logic [31:0]                            clip_w,
   input  logic [30:0]                            light_range,
   input  ltrc_pkg::cfg_type                      cfg,
   output ltrc_pkg::side_type                     side,
   output logic [ltrc_pkg::RATIO_NUM_W-1:0]       num_rx,
   output logic [ltrc_pkg::RATIO_NUM_W-1:0]       num_ry,
   output logic [ltrc_pkg::RATIO_DEN_W-1:0]       den_r,
   output logic [ltrc_pkg::SCREEN_NUM_W-1:0]      num_sx,
   output logic [ltrc_pkg::SCREEN_NUM_W-1:0]      num_sy,
   output logic [ltrc_pkg::SCREEN_DEN_W-1:0]      den_s
);

   // stage 1: captured item
   logic        valid1_ff;
   logic        kind1_ff;
   logic [31:0] depth1_ff, cx1_ff, cy1_ff, cw1_ff;
   logic [30:0] range1_ff;

   // stage 2: early decisions and operands
   ltrc_pkg::side_type side2_ff, side2_in;
   logic [30:0] range2_ff, range2_in;
   logic [30:0] pd2_ff, pd2_in;
   logic [32:0] magx2_ff, magx2_in, magy2_ff, magy2_in;
   logic [32:0] den2_ff, den2_in;

   // stage 3: products
   ltrc_pkg::side_type side3_ff;
   logic [ltrc_pkg::RATIO_NUM_W-1:0]  numrx3_ff, numry3_ff;
   logic [ltrc_pkg::SCREEN_NUM_W-1:0] numsx3_ff, numsy3_ff;
   logic [ltrc_pkg::SCREEN_DEN_W-1:0] den3_ff;
   logic [30:0] pd3_ff;

   logic [33:0] lo_sum, hi_diff;
   logic        near_cull, far_cull, depth_pos, w_pos;
   logic [32:0] numx, numy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
      kind1_ff  <= kind;
      depth1_ff <= view_depth;
      cx1_ff    <= clip_x;
      cy1_ff    <= clip_y;
      cw1_ff    <= clip_w;
      range1_ff <= light_range;
   end

   always_comb begin
      range2_in = (range1_ff < ltrc_pkg::RANGE_MIN_Q) ? ltrc_pkg::RANGE_MIN_Q : range1_ff;
      lo_sum    = {{2{depth1_ff[31]}}, depth1_ff} + {3'b000, range2_in};
      hi_diff   = {{2{depth1_ff[31]}}, depth1_ff} - {3'b000, range2_in};
      near_cull = $signed(lo_sum) <= $signed({3'b000, cfg.near_plane});
      far_cull  = $signed(hi_diff) > $signed({3'b000, cfg.far_plane});
      depth_pos = !depth1_ff[31] && (depth1_ff != '0);
      w_pos     = !cw1_ff[31] && (cw1_ff != '0);

      side2_in.valid   = valid1_ff;
      side2_in.geom    = 1'b0;
      side2_in.verdict = ltrc_pkg::VERDICT_CULLED;
      priority if (kind1_ff) begin
         side2_in.verdict = ltrc_pkg::VERDICT_ALL;
      end else if (near_cull || far_cull) begin
         side2_in.verdict = ltrc_pkg::VERDICT_CULLED;
      end else if (!depth_pos) begin
         side2_in.verdict = ltrc_pkg::VERDICT_ALL;
      end else if (!w_pos) begin
         side2_in.verdict = ltrc_pkg::VERDICT_CULLED;
      end else begin
         side2_in.geom = 1'b1;
      end

      pd2_in = (!depth1_ff[31] && (depth1_ff[30:0] > cfg.near_plane)) ?
               depth1_ff[30:0] : cfg.near_plane;

      numx = {cx1_ff[31], cx1_ff} + {cw1_ff[31], cw1_ff};
      numy = {cw1_ff[31], cw1_ff} - {cy1_ff[31], cy1_ff};
      side2_in.neg_x = numx[32];
      side2_in.neg_y = numy[32];
      magx2_in = numx[32] ? (33'd0 - numx) : numx;
      magy2_in = numy[32] ? (33'd0 - numy) : numy;
      den2_in  = {cw1_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff <= '0;
         side3_ff <= '0;
      end else begin
         side2_ff <= side2_in;
         side3_ff <= side2_ff;
      end
      range2_ff <= range2_in;
      pd2_ff    <= pd2_in;
      magx2_ff  <= magx2_in;
      magy2_ff  <= magy2_in;
      den2_ff   <= den2_in;

      numrx3_ff <= ltrc_pkg::RATIO_NUM_W'(cfg.scale_x) * ltrc_pkg::RATIO_NUM_W'(range2_ff);
      numry3_ff <= ltrc_pkg::RATIO_NUM_W'(cfg.scale_y) * ltrc_pkg::RATIO_NUM_W'(range2_ff);
      numsx3_ff <= {46'(magx2_ff) * 46'(cfg.dim_x), 16'd0};
      numsy3_ff <= {46'(magy2_ff) * 46'(cfg.dim_y), 16'd0};
      pd3_ff    <= pd2_ff;
      den3_ff   <= den2_ff;
   end

   assign side   = side3_ff;
   assign num_rx = numrx3_ff;
   assign num_ry = numry3_ff;
   assign den_r  = pd3_ff;
   assign num_sx = numsx3_ff;
   assign num_sy = numsy3_ff;
   assign den_s  = den3_ff;

endmodule

/* hw/rtl/ltrc_div.sv */
// Restoring divider, STEP quotient bits per register stage.
// sat flags a quotient that does not fit in Q_W bits.
module ltrc_div #(
   parameter int NUM_W = ltrc_pkg::RATIO_NUM_W,
   parameter int DEN_W = ltrc_pkg::RATIO_DEN_W,
   parameter int Q_W   = ltrc_pkg::RATIO_Q_W,
   parameter int STEP  = ltrc_pkg::DIV_STEP
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo,
   output logic             rem_nz,
   output logic             sat
);

   localparam int STAGES = Q_W / STEP;

   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [Q_W-1:0]   low_ff [STAGES];
   logic [Q_W-1:0]   quo_ff [STAGES];
   logic             sat_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DEN_W-1:0] rem_src, den_src, rem_in;
      logic [Q_W-1:0]   low_src, quo_src, low_in, quo_in;
      logic             sat_src;
      logic [DEN_W:0]   trial;

      if (s == 0) begin : g_first
         assign rem_src = DEN_W'(num[NUM_W-1:Q_W]);
         assign low_src = num[Q_W-1:0];
         assign quo_src = '0;
         assign den_src = den;
         assign sat_src = DEN_W'(num[NUM_W-1:Q_W]) >= den;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign low_src = low_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign den_src = den_ff[s-1];
         assign sat_src = sat_ff[s-1];
      end

      always_comb begin
         rem_in = rem_src;
         low_in = low_src;
         quo_in = quo_src;
         trial  = '0;
         for (int i = 0; i < STEP; i++) begin
            trial  = {rem_in, low_in[Q_W-1]};
            low_in = low_in << 1;
            if (trial >= {1'b0, den_src}) begin
               rem_in = DEN_W'(trial - {1'b0, den_src});
               quo_in = {quo_in[Q_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               quo_in = {quo_in[Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         low_ff[s] <= low_in;
         quo_ff[s] <= quo_in;
         den_ff[s] <= den_src;
         sat_ff[s] <= sat_src;
      end
   end

   assign quo    = quo_ff[STAGES-1];
   assign rem_nz = |rem_ff[STAGES-1];
   assign sat    = sat_ff[STAGES-1];

endmodule

/* hw/rtl/ltrc_back.sv */
module ltrc_back #(
   parameter int TILE_SIZE = ltrc_pkg::TILE_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ltrc_pkg::side_type                   side,
   input  logic [ltrc_pkg::DIM_W-1:0]           dim_x,
   input  logic [ltrc_pkg::DIM_W-1:0]           dim_y,
   input  logic [ltrc_pkg::RATIO_Q_W-1:0]       ratio_x,
   input  logic                                 ratio_x_sat,
   input  logic [ltrc_pkg::RATIO_Q_W-1:0]       ratio_y,
   input  logic                                 ratio_y_sat,
   input  logic [ltrc_pkg::SCREEN_Q_W-1:0]      scr_x,
   input  logic                                 scr_x_rem,
   input  logic                                 scr_x_sat,
   input  logic [ltrc_pkg::SCREEN_Q_W-1:0]      scr_y,
   input  logic                                 scr_y_rem,
   input  logic                                 scr_y_sat,
   output logic                                 strobe,
   output ltrc_pkg::verdict_type                verdict,
   output logic [7:0]                           tile_min_x,
   output logic [7:0]                           tile_max_x,
   output logic [7:0]                           tile_min_y,
   output logic [7:0]                           tile_max_y
);

   localparam int RX_DLY = ltrc_pkg::SCREEN_LAT - ltrc_pkg::RATIO_LAT;
   localparam int QW     = ltrc_pkg::SCREEN_Q_W;
   localparam int PW     = ltrc_pkg::POS_W;
   // floor(x / TILE_SIZE) as (x * RECIP) >> SHIFT, exact for x < 2**IDX_N
   localparam int IDX_N  = $clog2((2 ** ltrc_pkg::DIM_W) + TILE_SIZE);
   localparam int SHIFT  = IDX_N + $clog2(TILE_SIZE);
   localparam int MUL_W  = IDX_N + SHIFT + 1;
   localparam logic [MUL_W-1:0] RECIP = MUL_W'(((2 ** SHIFT) + TILE_SIZE - 1) / TILE_SIZE);

   ltrc_pkg::side_type side_ff [ltrc_pkg::SCREEN_LAT];
   logic [ltrc_pkg::RX_W-1:0] rx_ff [RX_DLY];
   logic [ltrc_pkg::RX_W-1:0] ry_ff [RX_DLY];

   ltrc_pkg::side_type side4_ff, side5_ff, side5_in;
   logic [PW-1:0] sx4_ff, sy4_ff, sx4_in, sy4_in;
   logic [ltrc_pkg::RX_W-1:0] rx4_ff, ry4_ff;
   logic [PW-1:0] minx5_ff, maxx5_ff, miny5_ff, maxy5_ff;
   logic [PW-1:0] minx5_in, maxx5_in, miny5_in, maxy5_in;

   logic        strobe_ff;
   ltrc_pkg::verdict_type verdict_ff;
   logic [7:0]  tminx_ff, tmaxx_ff, tminy_ff, tmaxy_ff;

   logic [ltrc_pkg::RATIO_Q_W-1:0] rat_x, rat_y;
   logic [QW:0] qx, qy;
   logic        offview;

   function automatic logic [PW-1:0] screen_fix(input logic [QW-1:0] q, input logic rem,
                                                input logic sat, input logic neg);
      logic [QW:0] full;
      full = {1'b0, q} + (QW+1)'(neg & rem);
      if (sat || (full > ltrc_pkg::SCREEN_LIM)) begin
         full = ltrc_pkg::SCREEN_LIM;
      end
      return neg ? (PW'(0) - PW'(full)) : PW'(full);
   endfunction

   function automatic logic [7:0] tile_idx(input logic [PW-1:0] px,
                                           input logic [ltrc_pkg::DIM_W-1:0] dim);
      logic [PW-17:0]            whole;
      logic [ltrc_pkg::DIM_W-1:0] pix;
      logic [IDX_N-1:0]          t, cnt, res;
      logic [MUL_W-1:0]          prod_t, prod_c;
      whole  = px[PW-1:16];
      pix    = (whole > (PW-16)'(dim)) ? dim : whole[ltrc_pkg::DIM_W-1:0];
      prod_t = MUL_W'(pix) * RECIP;
      prod_c = (MUL_W'(dim) + MUL_W'(TILE_SIZE - 1)) * RECIP;
      t      = IDX_N'(prod_t >> SHIFT);
      cnt    = IDX_N'(prod_c >> SHIFT);
      if (cnt == '0) begin
         cnt = IDX_N'(1);
      end
      res = (t > cnt - IDX_N'(1)) ? cnt - IDX_N'(1) : t;
      if (px[PW-1]) begin
         res = '0;
      end
      return res[7:0];
   endfunction

   // side data rides along the divider latency
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ltrc_pkg::SCREEN_LAT; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= side;
         for (int i = 1; i < ltrc_pkg::SCREEN_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // pixel radius, then delayed to meet the screen quotient
   assign rat_x = ratio_x_sat ? '1 : ratio_x;
   assign rat_y = ratio_y_sat ? '1 : ratio_y;

   always_ff @(posedge clock) begin
      rx_ff[0] <= ltrc_pkg::RX_W'((45'(rat_x) * 45'(dim_x)) >> 1);
      ry_ff[0] <= ltrc_pkg::RX_W'((45'(rat_y) * 45'(dim_y)) >> 1);
      for (int i = 1; i < RX_DLY; i++) begin
         rx_ff[i] <= rx_ff[i-1];
         ry_ff[i] <= ry_ff[i-1];
      end
   end

   assign sx4_in = screen_fix(scr_x, scr_x_rem, scr_x_sat, side_ff[ltrc_pkg::SCREEN_LAT-1].neg_x);
   assign sy4_in = screen_fix(scr_y, scr_y_rem, scr_y_sat, side_ff[ltrc_pkg::SCREEN_LAT-1].neg_y);
   assign qx = '0;
   assign qy = '0;

   always_comb begin
      minx5_in = sx4_ff - PW'(rx4_ff);
      maxx5_in = sx4_ff + PW'(rx4_ff);
      miny5_in = sy4_ff - PW'(ry4_ff);
      maxy5_in = sy4_ff + PW'(ry4_ff);
      offview  = maxx5_in[PW-1] || maxy5_in[PW-1] ||
                 ($signed(minx5_in) > $signed(PW'({dim_x, 16'd0}))) ||
                 ($signed(miny5_in) > $signed(PW'({dim_y, 16'd0}))) ||
                 (qx != qy);
      side5_in = side4_ff;
      if (side4_ff.geom) begin
         side5_in.verdict = offview ? ltrc_pkg::VERDICT_CULLED : ltrc_pkg::VERDICT_RECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff  <= '0;
         side5_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         side4_ff  <= side_ff[ltrc_pkg::SCREEN_LAT-1];
         side5_ff  <= side5_in;
         strobe_ff <= side5_ff.valid;
      end
      sx4_ff   <= sx4_in;
      sy4_ff   <= sy4_in;
      rx4_ff   <= rx_ff[RX_DLY-1];
      ry4_ff   <= ry_ff[RX_DLY-1];
      minx5_ff <= minx5_in;
      maxx5_ff <= maxx5_in;
      miny5_ff <= miny5_in;
      maxy5_ff <= maxy5_in;
      verdict_ff <= side5_ff.verdict;
      if (side5_ff.verdict == ltrc_pkg::VERDICT_RECT) begin
         tminx_ff <= tile_idx(minx5_ff, dim_x);
         tmaxx_ff <= tile_idx(maxx5_ff, dim_x);
         tminy_ff <= tile_idx(miny5_ff, dim_y);
         tmaxy_ff <= tile_idx(maxy5_ff, dim_y);
      end else begin
         tminx_ff <= '0;
         tmaxx_ff <= '0;
         tminy_ff <= '0;
         tmaxy_ff <= '0;
      end
   end

   assign strobe     = strobe_ff;
   assign verdict    = verdict_ff;
   assign tile_min_x = tminx_ff;
   assign tile_max_x = tmaxx_ff;
   assign tile_min_y = tminy_ff;
   assign tile_max_y = tmaxy_ff;

endmodule

/* hw/rtl/light_tile_rect_cull_core.sv */
// Light tile rectangle culling. One light is taken per clock whenever start is
// high and busy is low; busy is high only during reset. Each light yields one
// result on the rsp_ ports, marked by strobe for one cycle. The latency is set
// mainly by the 12-stage pipelined divider for the screen-space position
// (4 quotient bits per stage); results cannot be held off by the receiver. CSR
// writes take effect at once and should be made only while no transaction is
// in flight.
`include "assert_macros.svh"

module light_tile_rect_cull_core #(
   parameter int TILE_SIZE    = ltrc_pkg::TILE_SIZE_DEF,
   parameter int MAX_VIEWPORT = ltrc_pkg::MAX_VIEWPORT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [31:0]                       req_view_depth,
   input  logic [31:0]                       req_clip_x,
   input  logic [31:0]                       req_clip_y,
   input  logic [31:0]                       req_clip_w,
   input  logic [30:0]                       req_light_range,
   output logic                              strobe,
   output logic [1:0]                        rsp_verdict,
   output logic [7:0]                        rsp_tile_min_x,
   output logic [7:0]                        rsp_tile_max_x,
   output logic [7:0]                        rsp_tile_min_y,
   output logic [7:0]                        rsp_tile_max_y,
   input  logic                              csr_we,
   input  logic [ltrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ltrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ltrc_pkg::cfg_type  cfg_ff, cfg_eff;
   ltrc_pkg::side_type side3;
   ltrc_pkg::verdict_type verdict;

   logic [ltrc_pkg::RATIO_NUM_W-1:0]  num_rx, num_ry;
   logic [ltrc_pkg::RATIO_DEN_W-1:0]  den_r;
   logic [ltrc_pkg::SCREEN_NUM_W-1:0] num_sx, num_sy;
   logic [ltrc_pkg::SCREEN_DEN_W-1:0] den_s;
   logic [ltrc_pkg::RATIO_Q_W-1:0]    ratio_x, ratio_y;
   logic [ltrc_pkg::SCREEN_Q_W-1:0]   scr_x, scr_y;
   logic ratio_x_sat, ratio_y_sat, ratio_x_rem, ratio_y_rem;
   logic scr_x_rem, scr_y_rem, scr_x_sat, scr_y_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_x    <= ltrc_pkg::RST_SCALE;
         cfg_ff.scale_y    <= ltrc_pkg::RST_SCALE;
         cfg_ff.near_plane <= ltrc_pkg::RST_NEAR;
         cfg_ff.far_plane  <= ltrc_pkg::RST_FAR;
         cfg_ff.dim_x      <= ltrc_pkg::RST_WIDTH;
         cfg_ff.dim_y      <= ltrc_pkg::RST_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            ltrc_pkg::CSR_PROJ_SCALE_X:    cfg_ff.scale_x    <= csr_wdata[23:0];
            ltrc_pkg::CSR_PROJ_SCALE_Y:    cfg_ff.scale_y    <= csr_wdata[23:0];
            ltrc_pkg::CSR_NEAR_PLANE:      cfg_ff.near_plane <= csr_wdata;
            ltrc_pkg::CSR_FAR_PLANE:       cfg_ff.far_plane  <= csr_wdata;
            ltrc_pkg::CSR_VIEWPORT_WIDTH:  cfg_ff.dim_x      <= csr_wdata[ltrc_pkg::DIM_W-1:0];
            ltrc_pkg::CSR_VIEWPORT_HEIGHT: cfg_ff.dim_y      <= csr_wdata[ltrc_pkg::DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // viewport clamped to the supported maximum
   always_comb begin
      cfg_eff = cfg_ff;
      if (32'(cfg_ff.dim_x) > 32'(MAX_VIEWPORT)) begin
         cfg_eff.dim_x = ltrc_pkg::DIM_W'(MAX_VIEWPORT);
      end
      if (32'(cfg_ff.dim_y) > 32'(MAX_VIEWPORT)) begin
         cfg_eff.dim_y = ltrc_pkg::DIM_W'(MAX_VIEWPORT);
      end
   end

   assign busy = reset;

   ltrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (start && !busy),
      .kind        (req_kind),
      .view_depth  (req_view_depth),
      .clip_x      (req_clip_x),
      .clip_y      (req_clip_y),
      .clip_w      (req_clip_w),
      .light_range (req_light_range),
      .cfg         (cfg_eff),
      .side        (side3),
      .num_rx      (num_rx),
      .num_ry      (num_ry),
      .den_r       (den_r),
      .num_sx      (num_sx),
      .num_sy      (num_sy),
      .den_s       (den_s)
   );

   ltrc_div #(
      .NUM_W (ltrc_pkg::RATIO_NUM_W),
      .DEN_W (ltrc_pkg::RATIO_DEN_W),
      .Q_W   (ltrc_pkg::RATIO_Q_W),
      .STEP  (ltrc_pkg::DIV_STEP)
   ) u_div_rx (
      .clock (clock), .num (num_rx), .den (den_r),
      .quo (ratio_x), .rem_nz (ratio_x_rem), .sat (ratio_x_sat)
   );

   ltrc_div #(
      .NUM_W (ltrc_pkg::RATIO_NUM_W),
      .DEN_W (ltrc_pkg::RATIO_DEN_W),
      .Q_W   (ltrc_pkg::RATIO_Q_W),
      .STEP  (ltrc_pkg::DIV_STEP)
   ) u_div_ry (
      .clock (clock), .num (num_ry), .den (den_r),
      .quo (ratio_y), .rem_nz (ratio_y_rem), .sat (ratio_y_sat)
   );

   ltrc_div #(
      .NUM_W (ltrc_pkg::SCREEN_NUM_W),
      .DEN_W (ltrc_pkg::SCREEN_DEN_W),
      .Q_W   (ltrc_pkg::SCREEN_Q_W),
      .STEP  (ltrc_pkg::DIV_STEP)
   ) u_div_sx (
      .clock (clock), .num (num_sx), .den (den_s),
      .quo (scr_x), .rem_nz (scr_x_rem), .sat (scr_x_sat)
   );

   ltrc_div #(
      .NUM_W (ltrc_pkg::SCREEN_NUM_W),
      .DEN_W (ltrc_pkg::SCREEN_DEN_W),
      .Q_W   (ltrc_pkg::SCREEN_Q_W),
      .STEP  (ltrc_pkg::DIV_STEP)
   ) u_div_sy (
      .clock (clock), .num (num_sy), .den (den_s),
      .quo (scr_y), .rem_nz (scr_y_rem), .sat (scr_y_sat)
   );

   ltrc_back #(
      .TILE_SIZE (TILE_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .side        (side3),
      .dim_x       (cfg_eff.dim_x),
      .dim_y       (cfg_eff.dim_y),
      .ratio_x     (ratio_x),
      .ratio_x_sat (ratio_x_sat && !ratio_x_rem || ratio_x_sat),
      .ratio_y     (ratio_y),
      .ratio_y_sat (ratio_y_sat && !ratio_y_rem || ratio_y_sat),
      .scr_x       (scr_x),
      .scr_x_rem   (scr_x_rem),
      .scr_x_sat   (scr_x_sat),
      .scr_y       (scr_y),
      .scr_y_rem   (scr_y_rem),
      .scr_y_sat   (scr_y_sat),
      .strobe      (strobe),
      .verdict     (verdict),
      .tile_min_x  (rsp_tile_min_x),
      .tile_max_x  (rsp_tile_max_x),
      .tile_min_y  (rsp_tile_min_y),
      .tile_max_y  (rsp_tile_max_y)
   );

   assign rsp_verdict = verdict;

   `ASSERT_IMPLIES(a_fixed_latency, clock, reset, start && !busy, ##(ltrc_pkg::LATENCY) strobe)
   `ASSERT_IMPLIES(a_verdict_code, clock, reset, strobe, rsp_verdict != 2'd3)
   `ASSERT_IMPLIES(a_rect_ordered, clock, reset, strobe && (rsp_verdict == ltrc_pkg::VERDICT_RECT), (rsp_tile_min_x <= rsp_tile_max_x) && (rsp_tile_min_y <= rsp_tile_max_y))
   `ASSERT_IMPLIES(a_no_rect_zero, clock, reset, strobe && (rsp_verdict != ltrc_pkg::VERDICT_RECT), (rsp_tile_min_x | rsp_tile_max_x | rsp_tile_min_y | rsp_tile_max_y) == 8'd0)

endmodule

/* sim/tb_light_tile_rect_cull_core.sv */
`timescale 1ns / 100ps

module tb_light_tile_rect_cull_core;

   typedef struct {
      logic        kind;
      logic [31:0] depth;
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cw;
      logic [30:0] range;
   } light_type;

   typedef struct {
      ltrc_pkg::verdict_type verdict;
      logic [7:0]  min_x;
      logic [7:0]  max_x;
      logic [7:0]  min_y;
      logic [7:0]  max_y;
   } rect_type;

   typedef struct {
      light_type lt;
      logic      typed;
      rect_type  want;
   } dir_row_type;

   localparam int TILE = ltrc_pkg::TILE_SIZE_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RAND_PER_PHASE = 300;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_kind;
   logic [31:0] req_view_depth;
   logic [31:0] req_clip_x;
   logic [31:0] req_clip_y;
   logic [31:0] req_clip_w;
   logic [30:0] req_light_range;
   logic        strobe;
   logic [1:0]  rsp_verdict;
   logic [7:0]  rsp_tile_min_x;
   logic [7:0]  rsp_tile_max_x;
   logic [7:0]  rsp_tile_min_y;
   logic [7:0]  rsp_tile_max_y;
   logic        csr_we;
   logic [ltrc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ltrc_pkg::CSR_DATA_W-1:0] csr_wdata;

   ltrc_pkg::cfg_type cfg;
   rect_type pending_rects[$];
   int      mismatches;
   int      lights_sent;
   int      rects_checked;
   int      idle_cycles;
   int      verdict_seen[3];
   logic    no_idle;

   light_tile_rect_cull_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_view_depth(req_view_depth),
      .req_clip_x(req_clip_x), .req_clip_y(req_clip_y),
      .req_clip_w(req_clip_w), .req_light_range(req_light_range),
      .strobe(strobe), .rsp_verdict(rsp_verdict),
      .rsp_tile_min_x(rsp_tile_min_x), .rsp_tile_max_x(rsp_tile_max_x),
      .rsp_tile_min_y(rsp_tile_min_y), .rsp_tile_max_y(rsp_tile_max_y),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic longint unsigned clamp_dim(logic [ltrc_pkg::DIM_W-1:0] v);
      return (v > ltrc_pkg::MAX_VIEWPORT_DEF) ? ltrc_pkg::MAX_VIEWPORT_DEF : v;
   endfunction

   function automatic longint unsigned tiles_in(longint unsigned dim);
      longint unsigned c;
      c = (dim + TILE - 1) / TILE;
      return (c == 0) ? 1 : c;
   endfunction

   function automatic longint pixel_radius(longint unsigned scale, longint unsigned rng,
                                           longint unsigned pd, longint unsigned dim);
      longint unsigned ratio;
      ratio = (scale * rng) / pd;
      if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      return longint'((ratio * dim) >> 1);
   endfunction

   // floor(num * dim * 2^16 / 2w), saturated at +-2^47
   function automatic longint screen_pos(longint num, longint w, longint unsigned dim);
      logic neg;
      longint unsigned mag, den, p, q;
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      den = w * 2;
      p = (mag * dim) << 16;
      q = neg ? (p + den - 1) / den : p / den;
      if (q > (64'd1 << 47)) q = 64'd1 << 47;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [7:0] tile_of(longint px, longint unsigned count);
      longint unsigned t;
      if (px < 0) return 8'd0;
      t = longint'(px) / (TILE << 16);
      if (t > count - 1) t = count - 1;
      return t[7:0];
   endfunction

   function automatic rect_type predict_rect(light_type lt);
      rect_type r;
      longint unsigned vw, vh, rng, pd;
      longint d, cx, cy, cw, rx, ry, sx, sy, minx, maxx, miny, maxy;
      r = '{ltrc_pkg::VERDICT_CULLED, 8'd0, 8'd0, 8'd0, 8'd0};
      vw = clamp_dim(cfg.dim_x);
      vh = clamp_dim(cfg.dim_y);
      d = longint'($signed(lt.depth));
      cx = longint'($signed(lt.cx));
      cy = longint'($signed(lt.cy));
      cw = longint'($signed(lt.cw));
      rng = lt.range;
      if (lt.kind) begin
         r.verdict = ltrc_pkg::VERDICT_ALL;
         return r;
      end
      if (rng < ltrc_pkg::RANGE_MIN_Q) rng = ltrc_pkg::RANGE_MIN_Q;
      if (d + longint'(rng) <= longint'(cfg.near_plane)) return r;
      if (d - longint'(rng) > longint'(cfg.far_plane)) return r;
      if (d <= 0) begin
         r.verdict = ltrc_pkg::VERDICT_ALL;
         return r;
      end
      pd = (d > longint'(cfg.near_plane)) ? d : cfg.near_plane;
      rx = pixel_radius(cfg.scale_x, rng, pd, vw);
      ry = pixel_radius(cfg.scale_y, rng, pd, vh);
      if (cw <= 0) return r;
      sx = screen_pos(cx + cw, cw, vw);
      sy = screen_pos(cw - cy, cw, vh);
      minx = sx - rx;
      maxx = sx + rx;
      miny = sy - ry;
      maxy = sy + ry;
      if (maxx < 0 || maxy < 0 || minx > longint'(vw << 16) || miny > longint'(vh << 16))
         return r;
      r.verdict = ltrc_pkg::VERDICT_RECT;
      r.min_x = tile_of(minx, tiles_in(vw));
      r.max_x = tile_of(maxx, tiles_in(vw));
      r.min_y = tile_of(miny, tiles_in(vh));
      r.max_y = tile_of(maxy, tiles_in(vh));
      return r;
   endfunction

   // result checker: strobe and fields sampled before the edge updates them
   always @(posedge clock) begin
      rect_type want;
      if (!reset && strobe) begin
         if (pending_rects.size() == 0) begin
            $error("unexpected result, verdict %0d", rsp_verdict);
            mismatches++;
         end else begin
            want = pending_rects.pop_front();
            rects_checked++;
            if (rsp_verdict < 3) verdict_seen[rsp_verdict]++;
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, actual %0d", want.verdict, rsp_verdict);
               mismatches++;
            end
            if (rsp_tile_min_x !== want.min_x) begin
               $error("tile_min_x: expected %0d, actual %0d", want.min_x, rsp_tile_min_x);
               mismatches++;
            end
            if (rsp_tile_max_x !== want.max_x) begin
               $error("tile_max_x: expected %0d, actual %0d", want.max_x, rsp_tile_max_x);
               mismatches++;
            end
            if (rsp_tile_min_y !== want.min_y) begin
               $error("tile_min_y: expected %0d, actual %0d", want.min_y, rsp_tile_min_y);
               mismatches++;
            end
            if (rsp_tile_max_y !== want.max_y) begin
               $error("tile_max_y: expected %0d, actual %0d", want.max_y, rsp_tile_max_y);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drives one light and holds it until the transaction is taken
   task automatic send_light(light_type lt, logic typed, rect_type want);
      if (!no_idle) begin
         while ($urandom_range(99) < 8) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_kind <= lt.kind;
      req_view_depth <= lt.depth;
      req_clip_x <= lt.cx;
      req_clip_y <= lt.cy;
      req_clip_w <= lt.cw;
      req_light_range <= lt.range;
      do @(posedge clock); while (busy);
      pending_rects.insert(pending_rects.size(), typed ? want : predict_rect(lt));
      lights_sent++;
   endtask

   task automatic write_csr(logic [ltrc_pkg::CSR_IDX_W-1:0] idx,
                            logic [ltrc_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (ltrc_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task automatic load_cfg(ltrc_pkg::cfg_type c);
      write_csr(ltrc_pkg::CSR_PROJ_SCALE_X, ltrc_pkg::CSR_DATA_W'(c.scale_x));
      write_csr(ltrc_pkg::CSR_PROJ_SCALE_Y, ltrc_pkg::CSR_DATA_W'(c.scale_y));
      write_csr(ltrc_pkg::CSR_NEAR_PLANE, c.near_plane);
      write_csr(ltrc_pkg::CSR_FAR_PLANE, c.far_plane);
      write_csr(ltrc_pkg::CSR_VIEWPORT_WIDTH, ltrc_pkg::CSR_DATA_W'(c.dim_x));
      write_csr(ltrc_pkg::CSR_VIEWPORT_HEIGHT, ltrc_pkg::CSR_DATA_W'(c.dim_y));
      csr_we <= 1'b0;
      cfg = c;
   endtask

   function automatic light_type random_light();
      light_type lt;
      longint w, span;
      if ($urandom_range(99) < 25) begin
         lt.kind = $urandom_range(3) == 0;
         lt.depth = $urandom;
         lt.cx = $urandom;
         lt.cy = $urandom;
         lt.cw = $urandom;
         lt.range = 31'($urandom);
         return lt;
      end
      // plausible on-screen light with random content
      lt.kind = $urandom_range(99) < 4;
      w = $urandom_range(1 << 20, 1 << 8);
      span = w + w / 4;
      lt.cw = 32'(($urandom_range(99) < 5) ? -w : w);
      lt.cx = 32'(longint'($urandom_range(32'(2 * span))) - span);
      lt.cy = 32'(longint'($urandom_range(32'(2 * span))) - span);
      lt.depth = $urandom_range(200 << 16, 0) - ($urandom_range(9) == 0 ? (2 << 16) : 0);
      lt.range = 31'(($urandom_range(3) == 0) ? $urandom_range(4000)
                                               : $urandom_range(30 << 16));
      return lt;
   endfunction

   initial begin
      dir_row_type dir_tbl[16];
      ltrc_pkg::cfg_type phases[6];
      rect_type none;
      rect_type all_tiles;
      none = '{ltrc_pkg::VERDICT_CULLED, 8'd0, 8'd0, 8'd0, 8'd0};
      all_tiles = '{ltrc_pkg::VERDICT_ALL, 8'd0, 8'd0, 8'd0, 8'd0};
      dir_tbl = '{
         '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             31'h7FFF_FFFF}, 1'b1, all_tiles},
         '{'{1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0}, 1'b1, all_tiles},
         // depth at zero but straddling the near plane
         '{'{1'b0, 32'h0, 32'h0, 32'h0, 32'h1_0000, 31'h10_0000}, 1'b1, all_tiles},
         '{'{1'b0, 32'hFFF6_0000, 32'h0, 32'h0, 32'h1_0000, 31'h1_0000}, 1'b1, none},
         '{'{1'b0, 32'h8000_0000, 32'h0, 32'h0, 32'h1_0000, 31'h7FFF_FFFF}, 1'b1, none},
         '{'{1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1_0000, 31'h0}, 1'b1, none},
         '{'{1'b0, 32'hA_0000, 32'h0, 32'h0, 32'h0, 31'h1_0000}, 1'b1, none},
         '{'{1'b0, 32'hA_0000, 32'h0, 32'h0, 32'h8000_0000, 31'h1_0000}, 1'b1, none},
         '{'{1'b0, 32'hA_0000, 32'h0, 32'h0, 32'h1_0000, 31'h1_0000}, 1'b0, none},
         '{'{1'b0, 32'hA_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 31'h1_0000},
           1'b0, none},
         '{'{1'b0, 32'hA_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 31'h1_0000},
           1'b0, none},
         '{'{1'b0, 32'h1, 32'h0, 32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF}, 1'b0, none},
         '{'{1'b0, 32'h2_0000, 32'h1_0000, 32'hFFFF_0000, 32'h1_0000, 31'h0}, 1'b0, none},
         '{'{1'b0, 32'h2_0000, 32'hFFFF_0000, 32'h1_0000, 32'h1_0000, 31'h100},
           1'b0, none},
         '{'{1'b0, 32'h5_0000, 32'h8000, 32'h4000, 32'h1_0000, 31'h3_0000}, 1'b0, none},
         '{'{1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1_0000, 31'h7FFF_FFFF}, 1'b0, none}
      };
      phases = '{
         '{ltrc_pkg::RST_SCALE, ltrc_pkg::RST_SCALE, ltrc_pkg::RST_NEAR, ltrc_pkg::RST_FAR,
           ltrc_pkg::RST_WIDTH, ltrc_pkg::RST_HEIGHT},
         '{24'hFF_FFFF, 24'hFF_FFFF, 31'd0, 31'h7FFF_FFFF, 13'h1FFF, 13'd0},
         '{24'd0, 24'd0, 31'h7FFF_FFFF, 31'd0, 13'd0, 13'd4096},
         '{24'h2_8000, 24'h1_C000, 31'h1000, 31'd300 << 16, 13'd64, 13'd48},
         '{24'h1_0000, 24'h1_0000, 31'd0, 31'd200 << 16, 13'd4096, 13'd4097},
         '{24'h4_0000, 24'h0_4000, 31'h8000, 31'd150 << 16, 13'd1000, 13'd17}
      };
      mismatches = 0;
      lights_sent = 0;
      rects_checked = 0;
      verdict_seen = '{0, 0, 0};
      no_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_kind = 1'b0;
      req_view_depth = '0;
      req_clip_x = '0;
      req_clip_y = '0;
      req_clip_w = '0;
      req_light_range = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg = phases[0];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // registers still hold their reset values here
      foreach (dir_tbl[i]) send_light(dir_tbl[i].lt, dir_tbl[i].typed, dir_tbl[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         if (ph > 0) load_cfg(phases[ph]);
         no_idle = (ph == 3);
         for (int n = 0; n < RAND_PER_PHASE; n++) send_light(random_light(), 1'b0, none);
      end
      drain();
      // one random register setting to finish
      load_cfg('{24'($urandom), 24'($urandom), 31'($urandom_range(1 << 17)),
                 31'($urandom_range(1 << 26, 1 << 20)), 13'($urandom_range(4200)),
                 13'($urandom_range(4200))});
      for (int n = 0; n < 100; n++) send_light(random_light(), 1'b0, none);
      drain();

      $display("%0d lights sent over 7 register settings, %0d results checked",
               lights_sent, rects_checked);
      $display("verdicts seen: culled %0d, all tiles %0d, rectangle %0d",
               verdict_seen[0], verdict_seen[1], verdict_seen[2]);
      if (mismatches == 0 && pending_rects.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ltrc_pkg.sv
hw/rtl/ltrc_front.sv
hw/rtl/ltrc_div.sv
hw/rtl/ltrc_back.sv
hw/rtl/light_tile_rect_cull_core.sv
sim/tb_light_tile_rect_cull_core.sv
